// ----- hdl/bfbsp_pkg.sv -----
// ----------------------------------------------------------------------------
// bfbsp_pkg: shared types and codes of the best-fit buffer slot pool
// Field widths, mode and status codes, and the small control structs that
// travel between the top level and the slot cells.
// ----------------------------------------------------------------------------
package bfbsp_pkg;

  // Default geometry
  localparam int SLOTS_DEF     = 16;
  localparam int SIZE_BITS_DEF = 32;

  // Fixed field widths on the channels
  localparam int MODE_W = 2;
  localparam int REQ_W  = 32;
  localparam int IDX_W  = 4;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 32;
  localparam int MAX_W  = 32;

  localparam logic [MAX_W-1:0] MAX_SIZE_RST = 32'd16777216;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_PRELOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GET      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FREE_ALL = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_REUSED  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NEW     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_REFUSED = 3'd3;
  localparam logic [STAT_W-1:0] STAT_DONE    = 3'd4;
  localparam logic [STAT_W-1:0] STAT_IGNORED = 3'd5;

  // Update command for one slot cell
  typedef struct packed {
    logic load;       // write size and free mark
    logic load_free;  // free mark written with load
    logic set_free;   // mark the slot free
    logic clr_free;   // mark the slot used
  } cell_cmd_t;

  // Control part of the search token that walks the cell row
  typedef struct packed {
    logic vld;
    logic found;
  } scan_tok_t;

endpackage

// ----- hdl/bfbsp_cfg_if.sv -----
// ----------------------------------------------------------------------------
// bfbsp_cfg_if: configuration write channel
// Carries the max_size register value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfbsp_cfg_if import bfbsp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MAX_W-1:0] max_size;

  modport source (output valid, output max_size, input ready);
  modport sink   (input valid, input max_size, output ready);
endinterface

// ----- hdl/bfbsp_in_if.sv -----
// ----------------------------------------------------------------------------
// bfbsp_in_if: request channel
// Carries one pool request (mode, size, slot index, allocator grant).
// ----------------------------------------------------------------------------
interface bfbsp_in_if import bfbsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [REQ_W-1:0]  request_size;
  logic [IDX_W-1:0]  slot_index;
  logic              alloc_granted;

  modport source (output valid, output mode, output request_size, output slot_index,
                  output alloc_granted, input ready);
  modport sink   (input valid, input mode, input request_size, input slot_index,
                  input alloc_granted, output ready);
endinterface

// ----- hdl/bfbsp_out_if.sv -----
// ----------------------------------------------------------------------------
// bfbsp_out_if: result channel
// Carries the chosen slot, status and both running counters.
// ----------------------------------------------------------------------------
interface bfbsp_out_if import bfbsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  result_slot;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  reuses;
  logic [CNT_W-1:0]  allocations;

  modport source (output valid, output result_slot, output status, output reuses,
                  output allocations, input ready);
  modport sink   (input valid, input result_slot, input status, input reuses,
                  input allocations, output ready);
endinterface

// ----- hdl/best_fit_buffer_slot_pool_unit.sv -----
// ----------------------------------------------------------------------------
// best_fit_buffer_slot_pool_unit: best-fit buffer slot pool
// Table of slots searched for the smallest free fit by a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_chan  writes max_size, the largest slot size a get may reuse. Write
//             it only while no request is in flight; ready is always high.
//   in_chan   takes one request: preload, get, release or free-all.
//   out_chan  returns one result per request: slot, status and counters.
// Sequence:
//   A get sends a search token down the row of SLOTS cells, one cell per
//   cycle, then applies the update and loads the result into the output
//   register. Other modes skip the search and go straight to the update.
//   One request is in work at a time.
// Reset:
//   rst_n (synchronous, active low) empties the table, clears both counters
//   and restores max_size to its default.
// Stall:
//   The result holds in the output register while out_chan.ready is low; a
//   further request is accepted and worked on, then waits for that register.
// ----------------------------------------------------------------------------
module best_fit_buffer_slot_pool_unit import bfbsp_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bfbsp_cfg_if.sink    cfg_chan,
  bfbsp_in_if.sink     in_chan,
  bfbsp_out_if.source  out_chan
);

  localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam int XW   = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;
  localparam int RW   = (CNTW > IDX_W) ? CNTW : IDX_W;
  localparam int OW   = (IW > IDX_W) ? IW : IDX_W;
  localparam logic [XW-1:0] SIZE_ALL = XW'({SIZE_BITS{1'b1}});

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]           state_r;
  logic [MAX_W-1:0]     max_r;
  logic [MODE_W-1:0]    mode_r;
  logic [SIZE_BITS-1:0] req_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 grant_r;
  logic [SIZE_BITS-1:0] maxl_r;
  logic                 start_r;
  logic                 found_r;
  logic [IW-1:0]        best_r;
  logic [CNTW-1:0]      count_r;
  logic [CNT_W-1:0]     reuse_r;
  logic [CNT_W-1:0]     alloc_r;
  logic                 out_vld_r;
  logic [IDX_W-1:0]     out_slot_r;
  logic [STAT_W-1:0]    out_stat_r;
  logic [CNT_W-1:0]     out_reuse_r;
  logic [CNT_W-1:0]     out_alloc_r;

  logic                 acc;
  logic                 fin_go;
  logic                 full;
  logic                 rel_ok;
  logic [XW-1:0]        req_ext;
  logic [XW-1:0]        max_ext;
  logic [SIZE_BITS-1:0] maxl_nxt;
  logic [OW-1:0]        slot_nxt;
  logic [STAT_W-1:0]    stat_nxt;
  logic                 reuse_inc;
  logic                 alloc_inc;
  logic                 cnt_inc;

  scan_tok_t            tok      [SLOTS+1];
  logic [IW-1:0]        tok_idx  [SLOTS+1];
  logic [SIZE_BITS-1:0] tok_size [SLOTS+1];
  cell_cmd_t            cmd      [SLOTS];
  logic [SLOTS-1:0]     live;

  // Configuration register
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_SIZE_RST;
    end else if (cfg_chan.valid) begin
      max_r <= cfg_chan.max_size;
    end
  end

  // Request intake
  assign in_chan.ready = (state_r == S_IDLE);
  assign acc           = in_chan.valid && in_chan.ready;
  assign req_ext       = XW'(in_chan.request_size);
  assign max_ext       = XW'(max_r);
  assign maxl_nxt      = (max_ext > SIZE_ALL) ? SIZE_ALL[SIZE_BITS-1:0]
                                              : max_ext[SIZE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (acc) begin
      mode_r  <= in_chan.mode;
      req_r   <= req_ext[SIZE_BITS-1:0];
      idx_r   <= in_chan.slot_index;
      grant_r <= in_chan.alloc_granted;
      maxl_r  <= maxl_nxt;
    end
  end

  // Sequence: accept, search (get only), then update and emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b0;
    end else begin
      start_r <= acc && (in_chan.mode == MODE_GET);
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            state_r <= (in_chan.mode == MODE_GET) ? S_SCAN : S_FIN;
          end
        end
        S_SCAN: begin
          if (tok[SLOTS].vld) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Capture the search outcome from the end of the row
  always_ff @(posedge clk) begin
    if (state_r == S_SCAN && tok[SLOTS].vld) begin
      found_r <= tok[SLOTS].found;
      best_r  <= tok_idx[SLOTS];
    end
  end

  // Feed the head of the cell row
  assign tok[0]      = '{vld: start_r, found: 1'b0};
  assign tok_idx[0]  = '0;
  assign tok_size[0] = '0;

  // Cell row with per-cell update commands
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign live[i] = (CNTW'(i) < count_r);

    always_comb begin
      cmd[i].load      = fin_go && !full && (count_r == CNTW'(i)) &&
                         ((mode_r == MODE_PRELOAD) ||
                          (mode_r == MODE_GET && !found_r && grant_r));
      cmd[i].load_free = (mode_r == MODE_PRELOAD);
      cmd[i].set_free  = fin_go && live[i] &&
                         ((mode_r == MODE_FREE_ALL) ||
                          (mode_r == MODE_RELEASE && RW'(idx_r) == RW'(i)));
      cmd[i].clr_free  = fin_go && (mode_r == MODE_GET) && found_r &&
                         (best_r == IW'(i));
    end

    bfbsp_cell #(
      .SIZE_BITS (SIZE_BITS),
      .IW        (IW),
      .CELL_IDX  (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd[i]),
      .wr_size    (req_r),
      .live       (live[i]),
      .req        (req_r),
      .max_lim    (maxl_r),
      .tok_i      (tok[i]),
      .tok_idx_i  (tok_idx[i]),
      .tok_size_i (tok_size[i]),
      .tok_o      (tok[i+1]),
      .tok_idx_o  (tok_idx[i+1]),
      .tok_size_o (tok_size[i+1])
    );
  end

  // Result and bookkeeping for the request in hand
  assign fin_go = (state_r == S_FIN) && (!out_vld_r || out_chan.ready);
  assign full   = (count_r == CNTW'(SLOTS));
  assign rel_ok = (RW'(idx_r) < RW'(count_r));

  always_comb begin
    slot_nxt  = '0;
    stat_nxt  = STAT_DONE;
    reuse_inc = 1'b0;
    alloc_inc = 1'b0;
    cnt_inc   = 1'b0;
    unique case (mode_r)
      MODE_PRELOAD: begin
        if (full) begin
          stat_nxt = STAT_FULL;
        end else begin
          slot_nxt = OW'(count_r);
          cnt_inc  = 1'b1;
        end
      end
      MODE_GET: begin
        if (found_r) begin
          stat_nxt  = STAT_REUSED;
          slot_nxt  = OW'(best_r);
          reuse_inc = 1'b1;
        end else if (full) begin
          stat_nxt = STAT_FULL;
        end else if (!grant_r) begin
          stat_nxt = STAT_REFUSED;
        end else begin
          stat_nxt  = STAT_NEW;
          slot_nxt  = OW'(count_r);
          alloc_inc = 1'b1;
          cnt_inc   = 1'b1;
        end
      end
      MODE_RELEASE: begin
        stat_nxt = rel_ok ? STAT_DONE : STAT_IGNORED;
      end
      MODE_FREE_ALL: begin
        stat_nxt = STAT_DONE;
      end
    endcase
  end

  // Update counters and slot fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      reuse_r <= '0;
      alloc_r <= '0;
    end else if (fin_go) begin
      count_r <= count_r + CNTW'(cnt_inc);
      reuse_r <= reuse_r + CNT_W'(reuse_inc);
      alloc_r <= alloc_r + CNT_W'(alloc_inc);
    end
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fin_go) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_slot_r  <= slot_nxt[IDX_W-1:0];
      out_stat_r  <= stat_nxt;
      out_reuse_r <= reuse_r + CNT_W'(reuse_inc);
      out_alloc_r <= alloc_r + CNT_W'(alloc_inc);
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.result_slot = out_slot_r;
  assign out_chan.status      = out_stat_r;
  assign out_chan.reuses      = out_reuse_r;
  assign out_chan.allocations = out_alloc_r;

endmodule

// ----- hdl/bfbsp_cell.sv -----
// ----------------------------------------------------------------------------
// bfbsp_cell: one slot of the pool
// Holds a slot size and free mark, applies update commands, and compares
// itself against the search token passing by, handing the better candidate
// to the next cell through its token register.
// ----------------------------------------------------------------------------
module bfbsp_cell import bfbsp_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF,
  parameter int IW        = 4,
  parameter int CELL_IDX  = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_cmd_t            cmd,
  input  logic [SIZE_BITS-1:0] wr_size,
  input  logic                 live,
  input  logic [SIZE_BITS-1:0] req,
  input  logic [SIZE_BITS-1:0] max_lim,
  input  scan_tok_t            tok_i,
  input  logic [IW-1:0]        tok_idx_i,
  input  logic [SIZE_BITS-1:0] tok_size_i,
  output scan_tok_t            tok_o,
  output logic [IW-1:0]        tok_idx_o,
  output logic [SIZE_BITS-1:0] tok_size_o
);

  logic [SIZE_BITS-1:0] size_r;
  logic                 free_r;
  logic                 hit;
  scan_tok_t            tok_r;
  logic [IW-1:0]        tok_idx_r;
  logic [SIZE_BITS-1:0] tok_size_r;

  // Hold slot size; written only by a load
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      size_r <= wr_size;
    end
  end

  // Track the free mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= 1'b0;
    end else if (cmd.load) begin
      free_r <= cmd.load_free;
    end else if (cmd.set_free) begin
      free_r <= 1'b1;
    end else if (cmd.clr_free) begin
      free_r <= 1'b0;
    end
  end

  // Strictly smaller wins, so ties keep the lower index seen earlier
  assign hit = live && free_r && (size_r >= req) && (size_r <= max_lim) &&
               (!tok_i.found || (size_r < tok_size_i));

  // Advance the search token to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r.vld   <= tok_i.vld;
      tok_r.found <= tok_i.found || hit;
    end
  end

  always_ff @(posedge clk) begin
    tok_idx_r  <= hit ? IW'(CELL_IDX) : tok_idx_i;
    tok_size_r <= hit ? size_r : tok_size_i;
  end

  assign tok_o      = tok_r;
  assign tok_idx_o  = tok_idx_r;
  assign tok_size_o = tok_size_r;

endmodule
